/* rtl/core/ibpa_pkg.sv */
`timescale 1ns / 1ps
package ibpa_pkg;

    localparam int MAX_BUFFERS = 256;
    localparam int IDX_W       = 9;
    localparam int ADDR_W      = 8;
    localparam int SEQ_W       = 16;
    localparam int ST_W        = 3;

    localparam logic [1:0] MODE_ALLOC    = 2'd0;
    localparam logic [1:0] MODE_FREE     = 2'd1;
    localparam logic [1:0] MODE_SPECIFIC = 2'd2;
    localparam logic [1:0] MODE_LOOKUP   = 2'd3;

    localparam logic [ST_W-1:0] ST_NONE      = 3'd0;
    localparam logic [ST_W-1:0] ST_EXHAUSTED = 3'd1;
    localparam logic [ST_W-1:0] ST_ILLEGAL   = 3'd2;
    localparam logic [ST_W-1:0] ST_UNALLOC   = 3'd3;
    localparam logic [ST_W-1:0] ST_ALLOCATED = 3'd4;

    typedef struct packed {
        logic cfg_load;
        logic clear;
        logic capture;
        logic eval;
        logic wr_first;
        logic wr_second;
        logic finish;
    } ibpa_cmd_t;

    typedef struct packed {
        logic out_free;
        logic clr_last;
    } ibpa_stat_t;

endpackage

/* rtl/core/ibpa_ram.sv */
`timescale 1ns / 1ps
module ibpa_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* rtl/core/ibpa_ctrl.sv */
`timescale 1ns / 1ps
module ibpa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  ibpa_pkg::ibpa_stat_t stat,
    output ibpa_pkg::ibpa_cmd_t  cmd
);
    import ibpa_pkg::*;

    typedef enum logic [5:0] {
        S_CLR  = 6'b000001,
        S_IDLE = 6'b000010,
        S_EVAL = 6'b000100,
        S_WR1  = 6'b001000,
        S_WR2  = 6'b010000,
        S_FIN  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLR:   if (stat.clr_last) state_next = S_IDLE;
            S_IDLE:
                if (cfg_valid)
                begin
                    state_next = S_CLR;
                end
                else if (in_valid)
                begin
                    state_next = S_EVAL;
                end
            S_EVAL:  state_next = S_WR1;
            S_WR1:   state_next = S_WR2;
            S_WR2:   state_next = S_FIN;
            S_FIN:   if (stat.out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // a configuration write takes the idle slot ahead of an item
    assign cfg_ready     = (state_reg == S_IDLE);
    assign in_ready      = (state_reg == S_IDLE) && !cfg_valid;
    assign cmd.cfg_load  = (state_reg == S_IDLE) && cfg_valid;
    assign cmd.clear     = (state_reg == S_CLR);
    assign cmd.capture   = (state_reg == S_IDLE) && !cfg_valid && in_valid;
    assign cmd.eval      = (state_reg == S_EVAL);
    assign cmd.wr_first  = (state_reg == S_WR1);
    assign cmd.wr_second = (state_reg == S_WR2);
    assign cmd.finish    = (state_reg == S_FIN) && stat.out_free;
endmodule

/* rtl/core/ibpa_datapath.sv */
`timescale 1ns / 1ps
module ibpa_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ibpa_pkg::ibpa_cmd_t           cmd,
    output ibpa_pkg::ibpa_stat_t          stat,
    input  logic [ibpa_pkg::IDX_W-1:0]    cfg_data,
    input  logic [1:0]                    mode,
    input  logic [ibpa_pkg::IDX_W-1:0]    buf_index,
    input  logic [ibpa_pkg::SEQ_W-1:0]    seq_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          ok,
    output logic [ibpa_pkg::IDX_W-1:0]    out_index,
    output logic [ibpa_pkg::SEQ_W-1:0]    incarnation,
    output logic [ibpa_pkg::ST_W-1:0]     status,
    output logic [ibpa_pkg::IDX_W-1:0]    in_use
);
    import ibpa_pkg::*;

    localparam logic [IDX_W-1:0] ONE  = IDX_W'(1);
    localparam logic [IDX_W-1:0] FULL = IDX_W'(MAX_BUFFERS);

    logic [IDX_W-1:0]  pool_reg, head_reg, busy_cnt_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;

    logic [1:0]       mode_reg;
    logic [IDX_W-1:0] k_reg;
    logic [SEQ_W-1:0] seq_reg;
    logic [IDX_W-1:0] nx_reg, pr_reg, oh_reg;
    logic             unlink_reg, push_reg, res_ok_reg;
    logic [ST_W-1:0]  res_st_reg;
    logic [SEQ_W-1:0] res_inc_reg;

    logic             out_valid_reg, ok_reg;
    logic [IDX_W-1:0] out_index_reg, in_use_reg;
    logic [SEQ_W-1:0] inc_out_reg;
    logic [ST_W-1:0]  st_out_reg;

    // read port: address of the buffer the arriving item names
    logic [IDX_W-1:0]  k_in;
    logic [ADDR_W-1:0] raddr, ka;
    assign k_in  = (mode == MODE_ALLOC) ? head_reg : buf_index;
    assign raddr = ADDR_W'(k_in - ONE);
    assign ka    = ADDR_W'(k_reg - ONE);

    logic [IDX_W-1:0] next_rd, prev_rd;
    logic [SEQ_W-1:0] inc_rd;
    logic             busy_rd;

    logic              n_we, p_we, i_we, b_we;
    logic [ADDR_W-1:0] n_wa, p_wa, i_wa, b_wa;
    logic [IDX_W-1:0]  n_wd, p_wd;
    logic [SEQ_W-1:0]  i_wd;
    logic              b_wd;

    ibpa_ram #(.WIDTH(IDX_W), .DEPTH(MAX_BUFFERS)) u_next (
        .clk(clk), .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(raddr), .rdata(next_rd));
    ibpa_ram #(.WIDTH(IDX_W), .DEPTH(MAX_BUFFERS)) u_prev (
        .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(raddr), .rdata(prev_rd));
    ibpa_ram #(.WIDTH(SEQ_W), .DEPTH(MAX_BUFFERS)) u_inc (
        .clk(clk), .we(i_we), .waddr(i_wa), .wdata(i_wd), .raddr(raddr), .rdata(inc_rd));
    ibpa_ram #(.WIDTH(1), .DEPTH(MAX_BUFFERS)) u_busy (
        .clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(raddr), .rdata(busy_rd));

    // clearing pass: rebuild the chain for the buffer at the counter
    logic [IDX_W-1:0] clr_k, clr_nx, clr_pr;
    assign clr_k  = IDX_W'(clr_cnt_reg) + ONE;
    assign clr_nx = (clr_k <= pool_reg) ? IDX_W'(clr_cnt_reg) : '0;
    assign clr_pr = (clr_k < pool_reg) ? (clr_k + ONE) : '0;

    logic [IDX_W-1:0] nx_v, pr_v;
    logic [SEQ_W-1:0] inc_v;
    logic             busy_v, legal;
    assign nx_v   = next_rd;
    assign pr_v   = prev_rd;
    assign inc_v  = inc_rd;
    assign busy_v = busy_rd;
    assign legal  = (k_reg != '0) && (k_reg <= pool_reg);

    logic             ev_ok, ev_unlink, ev_push;
    logic [ST_W-1:0]  ev_st;
    logic [SEQ_W-1:0] ev_inc;

    always_comb
    begin
        ev_ok     = 1'b0;
        ev_unlink = 1'b0;
        ev_push   = 1'b0;
        ev_st     = ST_NONE;
        ev_inc    = '0;
        if (mode_reg == MODE_ALLOC)
        begin
            if (k_reg == '0)
            begin
                ev_st = ST_EXHAUSTED;
            end
            else
            begin
                ev_ok = 1'b1; ev_unlink = 1'b1; ev_inc = inc_v + SEQ_W'(1);
            end
        end
        else if (!legal)
        begin
            ev_st = ST_ILLEGAL;
        end
        else
        begin
            case (mode_reg)
                MODE_FREE:
                    if (busy_v)
                    begin
                        ev_ok = 1'b1; ev_push = 1'b1; ev_inc = inc_v;
                    end
                    else
                    begin
                        ev_st = ST_UNALLOC;
                    end
                MODE_SPECIFIC:
                    if (busy_v)
                    begin
                        ev_st = ST_ALLOCATED;
                    end
                    else
                    begin
                        ev_ok = 1'b1; ev_unlink = 1'b1; ev_inc = seq_reg;
                    end
                default:
                    if (busy_v)
                    begin
                        ev_ok = 1'b1; ev_inc = inc_v;
                    end
                    else
                    begin
                        ev_st = ST_UNALLOC;
                    end
            endcase
        end
    end

    // first write goes to the buffer itself, second to its neighbours
    always_comb
    begin
        n_we = 1'b0; n_wa = ka; n_wd = '0;
        p_we = 1'b0; p_wa = ka; p_wd = '0;
        i_we = cmd.wr_first && unlink_reg; i_wa = ka; i_wd = res_inc_reg;
        b_we = cmd.wr_first && (unlink_reg || push_reg); b_wa = ka;
        b_wd = unlink_reg;
        if (cmd.clear)
        begin
            n_we = 1'b1; n_wa = clr_cnt_reg; n_wd = clr_nx;
            p_we = 1'b1; p_wa = clr_cnt_reg; p_wd = clr_pr;
            i_we = 1'b1; i_wa = clr_cnt_reg; i_wd = '0;
            b_we = 1'b1; b_wa = clr_cnt_reg; b_wd = 1'b0;
        end
        else if (cmd.wr_first)
        begin
            n_we = unlink_reg || push_reg;
            n_wd = push_reg ? oh_reg : '0;
            p_we = unlink_reg || push_reg;
        end
        else if (cmd.wr_second)
        begin
            if (unlink_reg)
            begin
                n_we = (pr_reg != '0); n_wa = ADDR_W'(pr_reg - ONE); n_wd = nx_reg;
                p_we = (nx_reg != '0); p_wa = ADDR_W'(nx_reg - ONE); p_wd = pr_reg;
            end
            else if (push_reg)
            begin
                p_we = (oh_reg != '0); p_wa = ADDR_W'(oh_reg - ONE); p_wd = k_reg;
            end
        end
    end

    logic [IDX_W-1:0] cfg_sat;
    assign cfg_sat = (cfg_data > FULL) ? FULL : cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_reg      <= FULL;
            head_reg      <= FULL;
            busy_cnt_reg  <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            unlink_reg    <= 1'b0;
            push_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.cfg_load)
            begin
                pool_reg     <= cfg_sat;
                head_reg     <= cfg_sat;
                busy_cnt_reg <= '0;
            end
            else
            begin
                if (cmd.wr_first)
                begin
                    if (unlink_reg)
                    begin
                        busy_cnt_reg <= busy_cnt_reg + ONE;
                        if (pr_reg == '0) head_reg <= nx_reg;
                    end
                    else if (push_reg)
                    begin
                        if (busy_cnt_reg != '0) busy_cnt_reg <= busy_cnt_reg - ONE;
                        head_reg <= k_reg;
                    end
                end
            end
            // wraps back to zero after the last entry
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            if (cmd.eval)
            begin
                unlink_reg <= ev_unlink;
                push_reg   <= ev_push;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= mode;
            k_reg    <= k_in;
            seq_reg  <= seq_in;
        end
        if (cmd.eval)
        begin
            nx_reg      <= nx_v;
            pr_reg      <= pr_v;
            oh_reg      <= head_reg;
            res_ok_reg  <= ev_ok;
            res_st_reg  <= ev_st;
            res_inc_reg <= ev_inc;
        end
        if (cmd.finish)
        begin
            ok_reg        <= res_ok_reg;
            out_index_reg <= res_ok_reg ? k_reg : '0;
            inc_out_reg   <= res_inc_reg;
            st_out_reg    <= res_st_reg;
            in_use_reg    <= busy_cnt_reg;
        end
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign stat.clr_last = (clr_cnt_reg == '1);
    assign out_valid     = out_valid_reg;
    assign ok            = ok_reg;
    assign out_index     = out_index_reg;
    assign incarnation   = inc_out_reg;
    assign status        = st_out_reg;
    assign in_use        = in_use_reg;
endmodule

/* rtl/core/indexed_buffer_pool_allocator.sv */
`timescale 1ns / 1ps
// Order: the read happens at the accept; then evaluate, a write to the buffer
// itself and one to its neighbours in the link memories, and the result load.
// Flow: a new item is taken only once the previous result is loaded, as both
// writes share the single write port of each link memory; a result that waits holds it back too.
// Reset: asynchronous, active low; a clearing pass then builds a pool
// of 256 free buffers with counts zero; every configuration write repeats the pass.
module indexed_buffer_pool_allocator (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 mode,
    input  logic [ibpa_pkg::IDX_W-1:0] buf_index,
    input  logic [ibpa_pkg::SEQ_W-1:0] seq_in,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       ok,
    output logic [ibpa_pkg::IDX_W-1:0] out_index,
    output logic [ibpa_pkg::SEQ_W-1:0] incarnation,
    output logic [ibpa_pkg::ST_W-1:0]  status,
    output logic [ibpa_pkg::IDX_W-1:0] in_use,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [ibpa_pkg::IDX_W-1:0] cfg_data
);
    import ibpa_pkg::*;

    ibpa_cmd_t  cmd;
    ibpa_stat_t stat;

    ibpa_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .stat(stat), .cmd(cmd));

    ibpa_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .cfg_data(cfg_data),
        .mode(mode), .buf_index(buf_index), .seq_in(seq_in),
        .out_valid(out_valid), .out_ready(out_ready), .ok(ok),
        .out_index(out_index), .incarnation(incarnation), .status(status),
        .in_use(in_use));
endmodule

/* tb/tb_indexed_buffer_pool_allocator.sv */
`timescale 1ns / 1ps
module tb_indexed_buffer_pool_allocator;
    import ibpa_pkg::*;

    typedef struct packed {
        logic [1:0]       mode;
        logic [IDX_W-1:0] idx;
        logic [SEQ_W-1:0] seq;
    } op_t;

    typedef struct packed {
        logic             ok;
        logic [IDX_W-1:0] oidx;
        logic [SEQ_W-1:0] inc;
        logic [ST_W-1:0]  st;
        logic [IDX_W-1:0] used;
    } res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] mode = '0;
    logic [IDX_W-1:0] buf_index = '0;
    logic [SEQ_W-1:0] seq_in = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic ok;
    logic [IDX_W-1:0] out_index;
    logic [SEQ_W-1:0] incarnation;
    logic [ST_W-1:0] status;
    logic [IDX_W-1:0] in_use;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [IDX_W-1:0] cfg_data = '0;

    indexed_buffer_pool_allocator i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .mode(mode), .buf_index(buf_index), .seq_in(seq_in),
        .out_valid(out_valid), .out_ready(out_ready),
        .ok(ok), .out_index(out_index), .incarnation(incarnation),
        .status(status), .in_use(in_use),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    // predictor state
    int unsigned pool_sz;
    int unsigned nxt [0:MAX_BUFFERS];
    int unsigned prv [0:MAX_BUFFERS];
    int unsigned head;
    bit          busy [0:MAX_BUFFERS];
    logic [15:0] incs [0:MAX_BUFFERS];
    int unsigned busy_cnt;

    op_t  pending_ops[$];
    res_t expected_res[$];
    int   fails = 0;
    bit   calm = 1'b0;
    bit   cfg_req = 1'b0;
    logic [IDX_W-1:0] cfg_val;
    bit   cfg_done = 1'b0;
    int unsigned cycles = 0;

    function automatic void pool_rebuild(int unsigned n);
        if (n > MAX_BUFFERS) n = MAX_BUFFERS;
        pool_sz = n;
        for (int k = 0; k <= MAX_BUFFERS; k++) begin
            nxt[k] = 0; prv[k] = 0; busy[k] = 0; incs[k] = 0;
        end
        for (int unsigned k = 1; k <= n; k++) begin
            nxt[k] = k - 1;
            prv[k] = (k < n) ? k + 1 : 0;
        end
        head = n;
        busy_cnt = 0;
    endfunction

    function automatic void unlink_slot(int unsigned k);
        int unsigned nx;
        int unsigned pv;
        nx = nxt[k];
        pv = prv[k];
        if (pv != 0) nxt[pv] = nx; else head = nx;
        if (nx != 0) prv[nx] = pv;
        nxt[k] = 0; prv[k] = 0;
    endfunction

    function automatic res_t pool_apply(op_t o);
        res_t r;
        int unsigned i;
        bit legal;
        r = '0;
        i = o.idx;
        legal = (i != 0 && i <= pool_sz);
        if (o.mode == MODE_ALLOC) begin
            if (head == 0) r.st = ST_EXHAUSTED;
            else begin
                i = head;
                unlink_slot(i);
                busy[i] = 1;
                incs[i] = incs[i] + 16'd1;
                busy_cnt++;
                r.ok = 1; r.oidx = IDX_W'(i); r.inc = incs[i];
            end
        end else if (!legal) r.st = ST_ILLEGAL;
        else if (o.mode == MODE_FREE) begin
            if (!busy[i]) r.st = ST_UNALLOC;
            else begin
                busy[i] = 0;
                nxt[i] = head; prv[i] = 0;
                if (head != 0) prv[head] = i;
                head = i;
                if (busy_cnt > 0) busy_cnt--;
                r.ok = 1; r.oidx = IDX_W'(i); r.inc = incs[i];
            end
        end else if (o.mode == MODE_SPECIFIC) begin
            if (busy[i]) r.st = ST_ALLOCATED;
            else begin
                unlink_slot(i);
                busy[i] = 1;
                incs[i] = o.seq;
                busy_cnt++;
                r.ok = 1; r.oidx = IDX_W'(i); r.inc = o.seq;
            end
        end else begin
            if (!busy[i]) r.st = ST_UNALLOC;
            else begin
                r.ok = 1; r.oidx = IDX_W'(i); r.inc = incs[i];
            end
        end
        r.used = IDX_W'(busy_cnt);
        return r;
    endfunction

    // driver
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cfg_valid && cfg_ready) begin
            cfg_valid <= 1'b0;
            cfg_done <= 1'b1;
            pool_rebuild(cfg_data);
        end else if (cfg_req && !cfg_valid && !cfg_done) begin
            cfg_valid <= 1'b1;
            cfg_data <= cfg_val;
        end
        if (!cfg_req) cfg_done <= 1'b0;
        if (in_valid && in_ready) begin
            expected_res.push_back(pool_apply('{mode, buf_index, seq_in}));
        end
        if (!(in_valid && !in_ready)) begin
            if (!cfg_req && pending_ops.size() > 0
                && (calm || $urandom_range(99) >= 30)) begin
                op_t o;
                o = pending_ops.pop_front();
                in_valid <= 1'b1;
                mode <= o.mode; buf_index <= o.idx; seq_in <= o.seq;
            end else
                in_valid <= 1'b0;
        end
        out_ready <= calm || ($urandom_range(99) >= 30);
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_res.size() == 0) begin
                $error("unexpected result index %0d", out_index);
                fails++;
            end else begin
                res_t e;
                e = expected_res.pop_front();
                if (ok !== e.ok) begin
                    $error("ok exp %0d got %0d", e.ok, ok); fails++;
                end
                if (out_index !== e.oidx) begin
                    $error("out_index exp %0d got %0d", e.oidx, out_index); fails++;
                end
                if (incarnation !== e.inc) begin
                    $error("incarnation exp %0d got %0d", e.inc, incarnation); fails++;
                end
                if (status !== e.st) begin
                    $error("status exp %0d got %0d", e.st, status); fails++;
                end
                if (in_use !== e.used) begin
                    $error("in_use exp %0d got %0d", e.used, in_use); fails++;
                end
            end
        end
        if (cycles > 400000) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic add_op(logic [1:0] m, int unsigned i, int unsigned s);
        pending_ops.push_back('{m, i[IDX_W-1:0], s[SEQ_W-1:0]});
    endtask

    task automatic drain();
        while (pending_ops.size() > 0 || in_valid || expected_res.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic set_pool(int unsigned n);
        drain();
        cfg_val = n[IDX_W-1:0];
        cfg_req = 1'b1;
        wait (cfg_done);
        @(posedge clk);
        cfg_req = 1'b0;
        @(posedge clk);
    endtask

    // mostly legal traffic against the current pool, plus some junk indices
    task automatic random_phase(int n);
        for (int k = 0; k < n; k++) begin
            int unsigned r;
            int unsigned i;
            r = $urandom_range(99);
            if (r < 8 || pool_sz == 0) i = $urandom_range(511);
            else i = $urandom_range(pool_sz, 1);
            add_op(2'($urandom_range(3)), i, $urandom);
        end
    endtask

    initial begin
        pool_rebuild(MAX_BUFFERS);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        // directed
        add_op(MODE_ALLOC, 511, 16'hFFFF);
        add_op(MODE_LOOKUP, 256, 0);
        add_op(MODE_FREE, 256, 0);
        add_op(MODE_FREE, 256, 0);
        add_op(MODE_LOOKUP, 1, 0);
        add_op(MODE_SPECIFIC, 1, 16'hFFFF);
        add_op(MODE_SPECIFIC, 1, 0);
        add_op(MODE_ALLOC, 0, 0);
        add_op(MODE_FREE, 0, 0);
        add_op(MODE_LOOKUP, 257, 0);
        add_op(MODE_SPECIFIC, 511, 16'h5555);
        add_op(MODE_SPECIFIC, 128, 16'hAAAA);
        add_op(MODE_LOOKUP, 128, 0);
        add_op(MODE_FREE, 128, 0);
        set_pool(0);
        add_op(MODE_ALLOC, 0, 0);
        add_op(MODE_FREE, 1, 0);
        set_pool(1);
        add_op(MODE_ALLOC, 0, 0);
        add_op(MODE_ALLOC, 0, 0);
        add_op(MODE_FREE, 1, 0);
        add_op(MODE_ALLOC, 0, 0);
        // write above the maximum saturates
        set_pool(511);
        add_op(MODE_LOOKUP, 256, 0);
        drain();
        // sender holds until everything came back
        random_phase(300);
        drain();
        set_pool(5);
        random_phase(300);
        calm = 1'b1;
        random_phase(250);
        drain();
        calm = 1'b0;
        set_pool(256);
        for (int k = 0; k < 150; k++) add_op(MODE_ALLOC, 0, 0);
        random_phase(200);
        set_pool($urandom_range(40, 2));
        random_phase(150);
        drain();
        repeat (20) @(posedge clk);
        if (fails == 0 && expected_res.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

/* indexed_buffer_pool_allocator.f */
rtl/core/ibpa_pkg.sv
rtl/core/ibpa_ram.sv
rtl/core/ibpa_ctrl.sv
rtl/core/ibpa_datapath.sv
rtl/core/indexed_buffer_pool_allocator.sv
tb/tb_indexed_buffer_pool_allocator.sv
